// ----- rtl/bsbd_pkg.sv -----
// Shared types and constants for the bank-switched bus decoder.
// No dependencies; used by the top level and its checker.
package bsbd_pkg;

	typedef enum logic [1:0] {
		TGT_RAM  = 2'd0,
		TGT_PPU  = 2'd1,
		TGT_ROM  = 2'd2,
		TGT_NONE = 2'd3
	} target_t;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic [15:0] PPU_BASE   = 16'h2000;
	localparam logic [15:0] OPEN_BASE  = 16'h4000;
	localparam logic [15:0] CART_BASE  = 16'h8000;
	localparam logic [15:0] FIXED_BASE = 16'hC000;

	localparam int unsigned BANK_OFS_W = 14;   // 16 KB bank
	localparam int unsigned PPU_REG_W  = 3;

endpackage

// ----- rtl/bsbd_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module bsbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/bank_switched_bus_decoder.sv -----
// Bus decoder top level: work RAM, picture-chip registers, banked cartridge ROM.
// Depends on bsbd_pkg and bsbd_ram.
//
//  channel  | handshake          | fields
//  ---------+--------------------+------------------------------------------------
//  access   | start / busy       | req_type, address, write_data
//  result   | done (strobe)      | target, read_data, rom_address, ppu_register,
//           |                    | ppu_write_enable, ppu_write_value, bank_now
//
// One word accepted per clock; its result strobes on done in the next cycle, matching
// the registered read port of the work RAM. busy never rises.
// Reset clears the bank register and the result strobe; work RAM is not cleared.
// done is high for a single cycle per result; the result fields hold until the next accepted word.
module bank_switched_bus_decoder #(
	parameter int SWITCH_BANKS = 2,
	parameter int RAM_BYTES    = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	output logic        done,
	output logic [1:0]  target,
	output logic [7:0]  read_data,
	output logic [15:0] rom_address,
	output logic [2:0]  ppu_register,
	output logic        ppu_write_enable,
	output logic [7:0]  ppu_write_value,
	output logic        bank_now
);

	localparam int RAM_AW = $clog2(RAM_BYTES);
	localparam int BANK_W = (SWITCH_BANKS > 1) ? $clog2(SWITCH_BANKS) : 1;
	localparam logic [1:0] FIXED_PAGE = 2'(SWITCH_BANKS % 4);

	logic accept;
	logic is_wr;
	bsbd_pkg::target_t tgt;
	logic [BANK_W-1:0] bank_q, bank_next;
	logic [BANK_W-1:0] bank_mod [256];
	logic [1:0] page;
	logic [15:0] rom_addr;
	logic ram_rd;
	logic [7:0] ram_rdata;

	logic              done_s1;
	bsbd_pkg::target_t tgt_s1;
	logic              ram_rd_s1;
	logic [15:0]       rom_s1;
	logic [2:0]        preg_s1;
	logic              pwe_s1;
	logic [7:0]        pval_s1;
	logic              bank_s1;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign is_wr  = (req_type == bsbd_pkg::REQ_WRITE);

	always_comb begin
		if (address < bsbd_pkg::PPU_BASE) begin
			tgt = bsbd_pkg::TGT_RAM;
		end else if (address < bsbd_pkg::OPEN_BASE) begin
			tgt = bsbd_pkg::TGT_PPU;
		end else if (address >= bsbd_pkg::CART_BASE) begin
			tgt = bsbd_pkg::TGT_ROM;
		end else begin
			tgt = bsbd_pkg::TGT_NONE;
		end
	end

	// byte modulo bank count, worked out at elaboration
	for (genvar i = 0; i < 256; i++) begin : g_mod
		assign bank_mod[i] = BANK_W'(i % SWITCH_BANKS);
	end

	assign bank_next = (accept && is_wr && tgt == bsbd_pkg::TGT_ROM)
		? bank_mod[write_data] : bank_q;

	// bank*16K + offset, kept to 16 bits: only the low two bank bits survive
	assign page = (address >= bsbd_pkg::FIXED_BASE) ? FIXED_PAGE : 2'(bank_q);
	assign rom_addr = (tgt == bsbd_pkg::TGT_ROM && !is_wr)
		? {page, address[bsbd_pkg::BANK_OFS_W-1:0]} : 16'd0;

	assign ram_rd = accept && !is_wr && tgt == bsbd_pkg::TGT_RAM;

	// address mirror is the low index bits; a read never meets a write in the same cycle
	bsbd_ram #(
		.WIDTH(8),
		.DEPTH(RAM_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (accept && is_wr && tgt == bsbd_pkg::TGT_RAM),
		.waddr(address[RAM_AW-1:0]),
		.wdata(write_data),
		.re   (ram_rd),
		.raddr(address[RAM_AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q  <= '0;
			done_s1 <= 1'b0;
		end else begin
			bank_q  <= bank_next;
			done_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_s1    <= tgt;
			ram_rd_s1 <= ram_rd;
			rom_s1    <= rom_addr;
			preg_s1   <= (tgt == bsbd_pkg::TGT_PPU)
				? address[bsbd_pkg::PPU_REG_W-1:0] : '0;
			pwe_s1    <= (tgt == bsbd_pkg::TGT_PPU) && is_wr;
			pval_s1   <= ((tgt == bsbd_pkg::TGT_PPU) && is_wr) ? write_data : 8'd0;
			bank_s1   <= bank_next[0];
		end
	end

	assign done             = done_s1;
	assign target           = 2'(tgt_s1);
	assign read_data        = ram_rd_s1 ? ram_rdata : 8'd0;
	assign rom_address      = rom_s1;
	assign ppu_register     = preg_s1;
	assign ppu_write_enable = pwe_s1;
	assign ppu_write_value  = pval_s1;
	assign bank_now         = bank_s1;

endmodule

// ----- rtl/bsbd_checker.sv -----
// Port-level checker for bank_switched_bus_decoder, with its bind.
// Depends on bsbd_pkg.
module bsbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  target,
	input logic [7:0]  read_data,
	input logic [15:0] rom_address,
	input logic        ppu_write_enable,
	input logic [7:0]  ppu_write_value
);

	// every accepted word is followed by a result strobe in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted word produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without an accepted word");

	a_unmapped_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && target == 2'(bsbd_pkg::TGT_NONE)) |->
			(read_data == 8'd0 && rom_address == 16'd0 && !ppu_write_enable))
		else $error("unmapped access drove a payload");

	a_ppu_write_target: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ppu_write_enable) |-> target == 2'(bsbd_pkg::TGT_PPU))
		else $error("picture write outside the picture range");

	a_read_data_ram_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && target != 2'(bsbd_pkg::TGT_RAM)) |->
			(read_data == 8'd0 && (ppu_write_enable || ppu_write_value == 8'd0)))
		else $error("read data outside work RAM");

endmodule

bind bank_switched_bus_decoder bsbd_checker u_bsbd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.target          (target),
	.read_data       (read_data),
	.rom_address     (rom_address),
	.ppu_write_enable(ppu_write_enable),
	.ppu_write_value (ppu_write_value)
);

// ----- tb/sv/bank_switched_bus_decoder_checker.sv -----
// Result checker for the bank-switched bus decoder: decodes every accepted access
// word on its own copy of work RAM and the bank register, then compares each strobed result.
// Depends on bsbd_pkg.
module bank_switched_bus_decoder_checker
	import bsbd_pkg::*;
#(
	parameter int SWITCH_BANKS = 2,
	parameter int RAM_BYTES    = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        req_type,
	input  logic [15:0] address,
	input  logic [7:0]  write_data,
	input  logic        done,
	input  logic [1:0]  target,
	input  logic [7:0]  read_data,
	input  logic [15:0] rom_address,
	input  logic [2:0]  ppu_register,
	input  logic        ppu_write_enable,
	input  logic [7:0]  ppu_write_value,
	input  logic        bank_now,
	output int          fault_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          RAM_AW    = $clog2(RAM_BYTES);
	localparam logic [15:0] RAM_MASK  = 16'h07FF;
	localparam int          BANK_SPAN = 1 << BANK_OFS_W;

	typedef struct packed {
		target_t     tgt;
		logic [7:0]  rdata;
		logic [15:0] rom;
		logic [2:0]  preg;
		logic        pwe;
		logic [7:0]  pval;
		logic        bank;
	} bus_result_t;

	logic [7:0]  ram_image [RAM_BYTES];
	int          bank_reg = 0;
	bus_result_t decoded_q [$];
	int          result_num = 0;

	initial begin
		fault_count = 0;
		outstanding = 0;
	end

	// Decode one access and update the shadow RAM / bank register.
	function automatic bus_result_t decode_access(logic rt, logic [15:0] addr,
			logic [7:0] data);
		bus_result_t       res;
		logic [RAM_AW-1:0] idx;
		int                rom_calc;
		res = '0;
		res.tgt = TGT_NONE;
		if (addr < PPU_BASE) begin
			res.tgt = TGT_RAM;
			idx = RAM_AW'(addr & RAM_MASK);
			if (rt == REQ_WRITE)
				ram_image[idx] = data;
			else
				res.rdata = ram_image[idx];
		end else if (addr < OPEN_BASE) begin
			res.tgt = TGT_PPU;
			res.preg = addr[2:0];
			if (rt == REQ_WRITE) begin
				res.pwe = 1'b1;
				res.pval = data;
			end
		end else if (addr >= CART_BASE) begin
			res.tgt = TGT_ROM;
			if (rt == REQ_WRITE) begin
				bank_reg = int'(data) % SWITCH_BANKS;
			end else if (addr < FIXED_BASE) begin
				rom_calc = bank_reg * BANK_SPAN + int'(addr) - int'(CART_BASE);
				res.rom = rom_calc[15:0];
			end else begin
				// fixed bank sits right after the switchable ones
				rom_calc = SWITCH_BANKS * BANK_SPAN + int'(addr) - int'(FIXED_BASE);
				res.rom = rom_calc[15:0];
			end
		end
		res.bank = bank_reg[0];
		return res;
	endfunction

	always @(posedge clk) begin
		bus_result_t seen;
		bus_result_t want;
		logic        bad;
		if (arst_n) begin
			if (start && !busy)
				decoded_q.push_back(decode_access(req_type, address, write_data));
			if ($isunknown(done)) begin
				if (fault_count < 10)
					$display("done strobe unknown at %0t", $realtime);
				fault_count <= fault_count + 1;
			end else if (done) begin
				seen = '{tgt: target_t'(target), rdata: read_data, rom: rom_address,
					preg: ppu_register, pwe: ppu_write_enable, pval: ppu_write_value,
					bank: bank_now};
				if (decoded_q.size() == 0) begin
					if (fault_count < 10)
						$display("result word %0d arrived with nothing pending", result_num);
					fault_count <= fault_count + 1;
				end else begin
					want = decoded_q.pop_front();
					bad = (seen.tgt !== want.tgt) || (seen.rdata !== want.rdata) ||
						(seen.rom !== want.rom) || (seen.preg !== want.preg) ||
						(seen.pwe !== want.pwe) || (seen.pval !== want.pval) ||
						(seen.bank !== want.bank);
					if (bad) begin
						if (fault_count < 10) begin
							$display("result word %0d mismatch:", result_num);
							$display("  exp tgt=%0d rd=%h rom=%h reg=%0d we=%b wv=%h bank=%b",
								want.tgt, want.rdata, want.rom, want.preg, want.pwe,
								want.pval, want.bank);
							$display("  got tgt=%0d rd=%h rom=%h reg=%0d we=%b wv=%h bank=%b",
								seen.tgt, seen.rdata, seen.rom, seen.preg, seen.pwe,
								seen.pval, seen.bank);
						end
						fault_count <= fault_count + 1;
					end
				end
				result_num <= result_num + 1;
			end
		end
		outstanding <= decoded_q.size();
	end

endmodule

// ----- tb/sv/bank_switched_bus_decoder_tb.sv -----
// Testbench top for the bank-switched bus decoder: clock, reset, directed and random
// bus access words with random idle gaps, and the final verdict.
// Depends on bsbd_pkg, the decoder RTL and bank_switched_bus_decoder_checker.
module bank_switched_bus_decoder_tb;
	import bsbd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SWITCH_BANKS = 2;
	localparam int RAM_BYTES    = 2048;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        req_type;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic        done;
	logic [1:0]  target;
	logic [7:0]  read_data;
	logic [15:0] rom_address;
	logic [2:0]  ppu_register;
	logic        ppu_write_enable;
	logic [7:0]  ppu_write_value;
	logic        bank_now;
	int          fault_count;
	int          outstanding;

	// RAM locations already written, so reads never hit undefined bytes
	bit          ram_written [RAM_BYTES];
	int          written_idx [$];
	bit          no_idle = 1'b0;

	bank_switched_bus_decoder #(
		.SWITCH_BANKS(SWITCH_BANKS),
		.RAM_BYTES(RAM_BYTES)
	) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .address(address), .write_data(write_data),
		.done(done), .target(target), .read_data(read_data),
		.rom_address(rom_address), .ppu_register(ppu_register),
		.ppu_write_enable(ppu_write_enable), .ppu_write_value(ppu_write_value),
		.bank_now(bank_now)
	);

	bank_switched_bus_decoder_checker #(
		.SWITCH_BANKS(SWITCH_BANKS),
		.RAM_BYTES(RAM_BYTES)
	) decode_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .address(address), .write_data(write_data),
		.done(done), .target(target), .read_data(read_data),
		.rom_address(rom_address), .ppu_register(ppu_register),
		.ppu_write_enable(ppu_write_enable), .ppu_write_value(ppu_write_value),
		.bank_now(bank_now), .fault_count(fault_count), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Present one word, hold it until accepted, then maybe idle.
	task automatic issue_access(logic rt, logic [15:0] addr, logic [7:0] data);
		int gap;
		start <= 1'b1;
		req_type <= rt;
		address <= addr;
		write_data <= data;
		do @(posedge clk); while (busy);
		if (rt == REQ_WRITE && addr < PPU_BASE && !ram_written[addr[10:0]]) begin
			ram_written[addr[10:0]] = 1'b1;
			written_idx.push_back(int'(addr[10:0]));
		end
		gap = idle_len();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_access();
		int          pick;
		logic [15:0] addr;
		logic [10:0] idx;
		pick = $urandom_range(0, 99);
		if (pick < 36 && (pick < 18 || written_idx.size() == 0)) begin
			issue_access(REQ_WRITE, 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
		end else if (pick < 36) begin
			// read back a written byte through a random mirror
			idx = 11'(written_idx[$urandom_range(0, written_idx.size() - 1)]);
			addr = {3'b000, 2'($urandom_range(0, 3)), idx};
			issue_access(REQ_READ, addr, 8'($urandom));
		end else if (pick < 56) begin
			issue_access(1'($urandom), 16'($urandom_range(16'h2000, 16'h3FFF)), 8'($urandom));
		end else if (pick < 64) begin
			issue_access(1'($urandom), 16'($urandom_range(16'h4000, 16'h7FFF)), 8'($urandom));
		end else if (pick < 90) begin
			issue_access(REQ_READ, 16'($urandom_range(16'h8000, 16'hFFFF)), 8'($urandom));
		end else begin
			issue_access(REQ_WRITE, 16'($urandom_range(16'h8000, 16'hFFFF)), 8'($urandom));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= REQ_READ;
		address <= '0;
		write_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// work RAM boundaries and mirroring
		issue_access(REQ_WRITE, 16'h0000, 8'h00);
		issue_access(REQ_WRITE, 16'h07FF, 8'hFF);
		issue_access(REQ_WRITE, 16'h1FFF, 8'hA5);
		issue_access(REQ_READ,  16'h0000, 8'hFF);
		issue_access(REQ_READ,  16'h07FF, 8'h00);
		issue_access(REQ_READ,  16'h17FF, 8'h00);
		issue_access(REQ_WRITE, 16'h0800, 8'h5A);
		issue_access(REQ_READ,  16'h0000, 8'h00);
		// picture registers; reads give no data
		issue_access(REQ_WRITE, 16'h2000, 8'hFF);
		issue_access(REQ_WRITE, 16'h3FFF, 8'h00);
		issue_access(REQ_READ,  16'h2007, 8'hFF);
		issue_access(REQ_READ,  16'h3FF8, 8'h00);
		// unmapped window
		issue_access(REQ_READ,  16'h4000, 8'h00);
		issue_access(REQ_WRITE, 16'h7FFF, 8'hFF);
		issue_access(REQ_READ,  16'h7FFF, 8'h00);
		// cartridge windows, bank switching with wide bank values
		issue_access(REQ_READ,  16'h8000, 8'h00);
		issue_access(REQ_READ,  16'hBFFF, 8'h00);
		issue_access(REQ_READ,  16'hC000, 8'h00);
		issue_access(REQ_READ,  16'hFFFF, 8'h00);
		issue_access(REQ_WRITE, 16'h8000, 8'hFF);
		issue_access(REQ_READ,  16'h8000, 8'h00);
		issue_access(REQ_READ,  16'hBFFF, 8'h00);
		issue_access(REQ_WRITE, 16'hFFFF, 8'hFE);
		issue_access(REQ_WRITE, 16'hC123, 8'h03);
		issue_access(REQ_READ,  16'h9234, 8'h00);

		repeat (1100) begin
			// occasionally switch into or out of a back-to-back burst
			if ($urandom_range(0, 49) == 0)
				no_idle = ~no_idle;
			random_access();
		end

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fault_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
